/* sv/wgg_pkg.sv */
// Shared types, constants and table functions of the wheel gap generator.
package wgg_pkg;

  localparam int unsigned MAX_ORDER   = 10;
  localparam int unsigned ORDER_CAP   = 10;
  localparam int unsigned ORDER_MIN   = 3;
  localparam int unsigned ORDER_W     = 4;
  localparam int unsigned VAL_W       = 33;
  localparam int unsigned GAP_W       = 8;
  localparam int unsigned RES_W       = 5;
  localparam int unsigned PRIME_COUNT = 8;
  localparam int unsigned STEP_W      = 3;

  localparam logic [ORDER_W-1:0] ORDER_LO = ORDER_W'(ORDER_MIN);
  localparam logic [ORDER_W-1:0] ORDER_HI =
    ORDER_W'((MAX_ORDER < ORDER_CAP) ? MAX_ORDER : ORDER_CAP);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [RES_W-1:0] res_t;
  typedef logic [ORDER_W-1:0] order_t;

  // Wheel primes from 5 upward, one residue counter each.
  localparam res_t WHEEL_PRIMES [PRIME_COUNT] = '{
    5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
  };

  typedef struct packed {
    val_t                   cand;
    val_t                   prev;
    logic                   step4;
    res_t [PRIME_COUNT-1:0] res;
  } wheel_state_t;

  typedef struct packed {
    logic [GAP_W-1:0] gap;
    val_t             residue;
    logic             wheel_end;
  } result_t;

  function automatic order_t clamp_order(input order_t order);
    order_t o;
    o = order;
    if (o < ORDER_LO) o = ORDER_LO;
    if (o > ORDER_HI) o = ORDER_HI;
    return o;
  endfunction

  // Primorial of the first order primes.
  function automatic val_t period_of(input order_t order);
    val_t p;
    case (order)
      4'd4:    p = 33'd210;
      4'd5:    p = 33'd2310;
      4'd6:    p = 33'd30030;
      4'd7:    p = 33'd510510;
      4'd8:    p = 33'd9699690;
      4'd9:    p = 33'd223092870;
      4'd10:   p = 33'd6469693230;
      default: p = 33'd30;
    endcase
    return p;
  endfunction

  function automatic wheel_state_t restart_state();
    wheel_state_t s;
    s.cand  = VAL_W'(1);
    s.prev  = VAL_W'(1);
    s.step4 = 1'b1;
    for (int i = 0; i < PRIME_COUNT; i++) begin
      s.res[i] = RES_W'(1);
    end
    return s;
  endfunction

endpackage

/* sv/wgg_step.sv */
// One wheel tick: candidate step, residue counter update, coprime test and gap.
module wgg_step (
  input  wgg_pkg::wheel_state_t state_i,
  input  logic                  restart_i,
  input  wgg_pkg::val_t         period_i,
  input  wgg_pkg::order_t       order_i,
  output wgg_pkg::wheel_state_t state_o,
  output logic                  emit_o,
  output wgg_pkg::result_t      result_o
);
  import wgg_pkg::*;

  wheel_state_t           cur;
  logic [STEP_W-1:0]      step;
  val_t                   next;
  val_t                   wrap_val;
  res_t [PRIME_COUNT-1:0] nres;
  logic [RES_W:0]         sum [PRIME_COUNT];
  logic                   coprime;

  assign cur      = restart_i ? restart_state() : state_i;
  assign step     = cur.step4 ? STEP_W'(4) : STEP_W'(2);
  assign next     = cur.cand + VAL_W'(step);
  assign wrap_val = period_i + VAL_W'(1);

  always_comb begin
    coprime = 1'b1;
    for (int i = 0; i < PRIME_COUNT; i++) begin
      sum[i] = {1'b0, cur.res[i]} + (RES_W+1)'(step);
      // one subtract suffices: residue below prime and step below 5
      if (sum[i] >= {1'b0, WHEEL_PRIMES[i]}) begin
        sum[i] = sum[i] - {1'b0, WHEEL_PRIMES[i]};
      end
      nres[i] = sum[i][RES_W-1:0];
      if ((i < int'(order_i) - 2) && (nres[i] == '0)) begin
        coprime = 1'b0;
      end
    end
  end

  always_comb begin
    if (next >= period_i) begin
      // close the wheel and start over at 1
      state_o            = restart_state();
      emit_o             = 1'b1;
      result_o.gap       = GAP_W'(wrap_val - cur.prev);
      result_o.residue   = wrap_val;
      result_o.wheel_end = 1'b1;
    end else begin
      state_o.cand       = next;
      state_o.prev       = coprime ? next : cur.prev;
      state_o.step4      = ~cur.step4;
      state_o.res        = nres;
      emit_o             = coprime;
      result_o.gap       = GAP_W'(next - cur.prev);
      result_o.residue   = next;
      result_o.wheel_end = 1'b0;
    end
  end

endmodule

/* sv/wheel_gap_generator_top.sv */
// Top level of the prime wheel gap generator: request and result registers.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  in       | input     | in_valid_i / in_ready_o    | restart_i
//  out      | output    | out_valid_o / out_ready_i  | gap_o, residue_o, wheel_end_o
//  cfg      | input     | cfg_we_i (no wait)         | cfg_wdata_i (wheel order)
//
// A request is registered on accept and processed when the result register is free,
// so one request per clock is sustained while results are taken. A result passes from
// the request register through the wheel step into the result register. A request
// that hits a multiple of an active prime gives no result. Reset sets order 3
// (period 30) and the wheel at 1. A stalled result holds the request register; a new
// request is taken whenever that register drains.
module wheel_gap_generator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wgg_pkg::GAP_W-1:0]       gap_o,
  output wgg_pkg::val_t                   residue_o,
  output logic                            wheel_end_o,
  input  logic                            cfg_we_i,
  input  logic [wgg_pkg::ORDER_W-1:0]     cfg_wdata_i
);
  import wgg_pkg::*;

  order_t       order_q;
  val_t         period_q;
  wheel_state_t st_q, st_d;
  logic         in_valid_q;
  logic         restart_q;
  logic         out_valid_q, out_valid_d;
  result_t      out_q, result;
  logic         emit;
  logic         advance;
  logic         accept;
  order_t       new_order;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign new_order  = clamp_order(cfg_wdata_i);

  wgg_step u_step (
    .state_i  (st_q),
    .restart_i(restart_q),
    .period_i (period_q),
    .order_i  (order_q),
    .state_o  (st_d),
    .emit_o   (emit),
    .result_o (result)
  );

  always_comb begin
    if (advance) begin
      out_valid_d = emit;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= ORDER_LO;
      period_q    <= period_of(ORDER_LO);
      st_q        <= restart_state();
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept || (in_valid_q && !advance);
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        // new order restarts the wheel
        order_q  <= new_order;
        period_q <= period_of(new_order);
        st_q     <= restart_state();
      end else if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      restart_q <= restart_i;
    end
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gap_o       = out_q.gap;
  assign residue_o   = out_q.residue;
  assign wheel_end_o = out_q.wheel_end;

  a_cand_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.cand[0] == 1'b1)
    else $error("wheel candidate is even");

  a_cand_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.cand < period_q)
    else $error("wheel candidate reached the period");

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.res[0] < WHEEL_PRIMES[0]) && (st_q.res[PRIME_COUNT-1] < WHEEL_PRIMES[PRIME_COUNT-1]))
    else $error("residue counter out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("request refused without a stalled result");

endmodule

/* sim/wheel_gap_checker.sv */
// Checker for the wheel gap generator: predicts each gap result and compares it.
`timescale 1ns / 1ps

module wheel_gap_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic                        restart_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [wgg_pkg::GAP_W-1:0]   gap_o,
  input  wgg_pkg::val_t               residue_o,
  input  logic                        wheel_end_o,
  input  logic                        cfg_we_i,
  input  logic [wgg_pkg::ORDER_W-1:0] cfg_wdata_i,
  output int                          errors_o,
  output int                          pending_o
);
  import wgg_pkg::*;

  localparam int LEAD_PRIMES [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};

  order_t  wheel_order;
  val_t    cand;
  val_t    prev_coprime;
  val_t    period;
  logic    step_four;
  int      prime_ctr [PRIME_COUNT];
  result_t gaps_due [$];

  function automatic int live_order();
    order_t o;
    o = wheel_order;
    if (o < ORDER_LO) o = ORDER_LO;
    if (o > ORDER_HI) o = ORDER_HI;
    return int'(o);
  endfunction

  task automatic rewind_wheel();
    longint prod;
    prod = 1;
    for (int i = 0; i < live_order(); i++) prod = prod * LEAD_PRIMES[i];
    period       = VAL_W'(prod);
    cand         = VAL_W'(1);
    prev_coprime = VAL_W'(1);
    step_four    = 1'b1;
    for (int i = 0; i < PRIME_COUNT; i++) prime_ctr[i] = 1;
  endtask

  task automatic advance_wheel(input logic restart);
    result_t r;
    val_t    nxt;
    int      step;
    int      live;
    bit      coprime;
    if (restart) rewind_wheel();
    step = step_four ? 4 : 2;
    nxt  = cand + VAL_W'(step);
    if (nxt >= period) begin
      // wrap: close the period and start over at 1
      r.residue   = period + VAL_W'(1);
      r.gap       = GAP_W'(r.residue - prev_coprime);
      r.wheel_end = 1'b1;
      gaps_due.push_back(r);
      rewind_wheel();
    end else begin
      cand      = nxt;
      step_four = ~step_four;
      live      = live_order() - 2;
      coprime   = 1'b1;
      for (int i = 0; i < PRIME_COUNT; i++) begin
        prime_ctr[i] += step;
        if (prime_ctr[i] >= int'(WHEEL_PRIMES[i])) prime_ctr[i] -= int'(WHEEL_PRIMES[i]);
        if (i < live && prime_ctr[i] == 0) coprime = 1'b0;
      end
      if (coprime) begin
        r.residue    = cand;
        r.gap        = GAP_W'(cand - prev_coprime);
        r.wheel_end  = 1'b0;
        prev_coprime = cand;
        gaps_due.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      wheel_order = ORDER_LO;
      rewind_wheel();
      gaps_due.delete();
      errors_o = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (gaps_due.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result, expected none, actual gap %0d residue %0d end %0b",
                   $time, gap_o, residue_o, wheel_end_o);
        end else begin
          want = gaps_due.pop_front();
          if (gap_o !== want.gap) begin
            errors_o++;
            $display("%0t: gap expected %0d actual %0d", $time, want.gap, gap_o);
          end
          if (residue_o !== want.residue) begin
            errors_o++;
            $display("%0t: residue expected %0d actual %0d", $time, want.residue, residue_o);
          end
          if (wheel_end_o !== want.wheel_end) begin
            errors_o++;
            $display("%0t: wheel_end expected %0b actual %0b", $time, want.wheel_end,
                     wheel_end_o);
          end
        end
      end
      // a new order also puts the wheel back at 1
      if (cfg_we_i) begin
        wheel_order = cfg_wdata_i;
        rewind_wheel();
      end
      if (in_valid_i && in_ready_o) advance_wheel(restart_i);
    end
    pending_o = gaps_due.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the wheel gap generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import wgg_pkg::*;

  localparam int HOLD_LEN   = 80;
  localparam int SETTLE     = 4;
  localparam int QUIET_MAX  = 3000;
  localparam int PHASE_ITEMS = 90;
  localparam order_t PHASE_ORDER [15] = '{
    4'd4, 4'd3, 4'd15, 4'd5, 4'd0, 4'd10, 4'd7, 4'd4,
    4'd2, 4'd6, 4'd8, 4'd9, 4'd11, 4'd3, 4'd4
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [GAP_W-1:0]    gap_o;
  val_t                residue_o;
  logic                wheel_end_o;
  logic                cfg_we_i    = 1'b0;
  logic [ORDER_W-1:0]  cfg_wdata_i = '0;

  int  errors;
  int  pending;
  bit  steady     = 1'b0;
  bit  hold_start = 1'b0;
  int  hold_cnt   = 0;
  int  quiet      = 0;

  always #2 clk_i = ~clk_i;

  wheel_gap_generator_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .gap_o       (gap_o),
    .residue_o   (residue_o),
    .wheel_end_o (wheel_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  wheel_gap_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .gap_o       (gap_o),
    .residue_o   (residue_o),
    .wheel_end_o (wheel_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Result side: random stalls, a steady stretch, and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= 0;
    end else if (hold_cnt != 0) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= hold_cnt - 1;
    end else if (hold_start) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= HOLD_LEN;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 11);
    end
  end

  // Abort when no channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic send_req(input logic rs);
    if (!steady && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hold requests until every expected result is back, then let the pipe settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_order(input order_t value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Order 3 from reset: non-coprime 25, the wrap at 30, then restarts.
    for (int k = 0; k < 12; k++) send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b1);
    // Out-of-range orders clamp to the ends.
    write_order(4'd0);
    for (int k = 0; k < 3; k++) send_req(1'b0);
    write_order(4'd15);
    for (int k = 0; k < 3; k++) send_req(1'b0);

    for (int ph = 0; ph < 15; ph++) begin
      write_order(PHASE_ORDER[ph]);
      steady <= (ph == 3);
      if (ph == 1) begin
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 7 && k == PHASE_ITEMS / 2) drain_results();
        send_req($urandom_range(99) < 5);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
